// ----- src/dqr_pkg.sv -----
// ----------------------------------------------------------------------------
// dqr_pkg: shared types for the reversible deque
// Request and result item types, operation and status codes, FSM states.
// ----------------------------------------------------------------------------
package dqr_pkg;

  // default number of ring slots
  localparam int unsigned DEPTH_DEF = 16;

  // operation codes
  typedef enum logic [1:0] {
    KIND_INS_HEAD = 2'd0,
    KIND_INS_TAIL = 2'd1,
    KIND_REM_HEAD = 2'd2,
    KIND_REVERSE  = 2'd3
  } kind_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // control states of the top level
  typedef enum logic {
    S_IDLE = 1'b0,
    S_WAIT = 1'b1
  } state_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] removed_value;
    logic        [4:0]  count;
  } out_item_t;

  // operation issued to the ring
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } ring_req_t;

endpackage

// ----- src/dqr_ring.sv -----
// ----------------------------------------------------------------------------
// dqr_ring: ring storage and pointers of the reversible deque
// Holds the entry memory, front/back pointers, count and direction flag.
// Applies one request per cycle; the result is valid the cycle after.
// ----------------------------------------------------------------------------
module dqr_ring #(
  parameter int unsigned DEPTH = dqr_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dqr_pkg::ring_req_t  req,
  output dqr_pkg::out_item_t  resp
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] i);
    ring_inc = (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] i);
    ring_dec = (i == '0) ? LAST_IDX : i - 1'b1;
  endfunction

  logic signed [31:0] mem [DEPTH];

  logic [IDX_W-1:0]   front_r, front_nxt;
  logic [IDX_W-1:0]   back_r, back_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               rev_r, rev_nxt;
  dqr_pkg::status_t   status_r, status_nxt;
  logic               pop_ok_r, pop_ok_nxt;
  logic signed [31:0] rd_data_r;

  logic               wr_en, rd_en;
  logic [IDX_W-1:0]   wr_addr, rd_addr;
  logic               full, empty;
  logic [CNT_W+4:0]   count_ext;

  assign full  = (count_r == FULL_CNT);
  assign empty = (count_r == '0);

  // decode the request into pointer moves and memory accesses
  always_comb begin
    front_nxt  = front_r;
    back_nxt   = back_r;
    count_nxt  = count_r;
    rev_nxt    = rev_r;
    status_nxt = status_r;
    pop_ok_nxt = pop_ok_r;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    wr_addr    = back_r;
    rd_addr    = front_r;
    if (req.valid) begin
      status_nxt = dqr_pkg::ST_DONE;
      pop_ok_nxt = 1'b0;
      unique case (req.item.kind)
        dqr_pkg::KIND_INS_HEAD,
        dqr_pkg::KIND_INS_TAIL: begin
          if (full) begin
            status_nxt = dqr_pkg::ST_FULL;
          end else begin
            wr_en     = 1'b1;
            count_nxt = count_r + 1'b1;
            // head insert goes to the physical front unless reversed
            if ((req.item.kind == dqr_pkg::KIND_INS_HEAD) != rev_r) begin
              front_nxt = ring_dec(front_r);
              wr_addr   = ring_dec(front_r);
            end else begin
              wr_addr  = back_r;
              back_nxt = ring_inc(back_r);
            end
          end
        end
        dqr_pkg::KIND_REM_HEAD: begin
          if (empty) begin
            status_nxt = dqr_pkg::ST_EMPTY;
          end else begin
            rd_en      = 1'b1;
            pop_ok_nxt = 1'b1;
            count_nxt  = count_r - 1'b1;
            if (rev_r) begin
              back_nxt = ring_dec(back_r);
              rd_addr  = ring_dec(back_r);
            end else begin
              rd_addr   = front_r;
              front_nxt = ring_inc(front_r);
            end
          end
        end
        dqr_pkg::KIND_REVERSE: begin
          // flip only when the order can actually change
          if (count_r >= CNT_W'(2)) begin
            rev_nxt = ~rev_r;
          end
        end
        default: begin
          status_nxt = dqr_pkg::ST_DONE;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r  <= '0;
      back_r   <= '0;
      count_r  <= '0;
      rev_r    <= 1'b0;
      status_r <= dqr_pkg::ST_DONE;
      pop_ok_r <= 1'b0;
    end else begin
      front_r  <= front_nxt;
      back_r   <= back_nxt;
      count_r  <= count_nxt;
      rev_r    <= rev_nxt;
      status_r <= status_nxt;
      pop_ok_r <= pop_ok_nxt;
    end
  end

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= req.item.value;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // build the result from the registered state
  assign count_ext          = {5'b0, count_r};
  assign resp.status        = status_r;
  assign resp.removed_value = pop_ok_r ? rd_data_r : 32'sd0;
  assign resp.count         = count_ext[4:0];

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("deque count above depth");

  a_ptr_meet : assert property (@(posedge clk) disable iff (!rst_n)
    (empty || full) |-> (front_r == back_r))
    else $error("pointers disagree with empty or full count");

  a_rev_guard : assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (rev_r != $past(rev_r))) |-> ($past(count_r) >= CNT_W'(2)))
    else $error("direction flipped with fewer than two entries");

  a_pop_needs_entry : assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !empty)
    else $error("memory read issued on empty deque");
`endif

endmodule

// ----- src/deque_with_reverse.sv -----
// ----------------------------------------------------------------------------
// deque_with_reverse: bounded double-ended queue with O(1) reverse
// Top level: request/result handshakes, sequencing and output register.
// ----------------------------------------------------------------------------
// Usage:
//   in_data carries one operation per request (insert head, insert tail,
//   remove head, reverse) with its value. out_data returns exactly one
//   result per request: status, the removed value (zero unless a remove
//   succeeded) and the entry count after the operation.
//   Both channels use valid/ready; a request is taken when in_valid and
//   in_ready are high at a rising edge, a result likewise on out_*.
// Sequencing:
//   After a request is taken, the ring registers the result, then the
//   output register loads it and out_valid rises. The block takes no new
//   request until that load, as only one request is in flight.
// Reset:
//   rst_n (synchronous, active low) empties the deque, clears the reverse
//   flag and drops any pending result. Memory contents are not cleared.
// Stalls:
//   A result held by a low out_ready sits in the output register while the
//   next request is still taken; its result waits in the ring until the
//   output register frees.
// ----------------------------------------------------------------------------
module deque_with_reverse #(
  parameter int unsigned DEPTH = dqr_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dqr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dqr_pkg::out_item_t out_data
);

  dqr_pkg::state_t    state_r, state_nxt;
  dqr_pkg::ring_req_t req;
  dqr_pkg::out_item_t resp;
  dqr_pkg::out_item_t out_data_r;
  logic               out_valid_r, out_valid_nxt;
  logic               load_out;

  dqr_ring #(
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .resp  (resp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dqr_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = dqr_pkg::S_WAIT;
        end
      end
      dqr_pkg::S_WAIT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = dqr_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = dqr_pkg::S_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready  = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      dqr_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      dqr_pkg::S_WAIT: begin
        load_out = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    req.valid = in_valid && in_ready;
    req.item  = in_data;
  end

  // hold the result until the receiver takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dqr_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= resp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || out_ready))
    else $error("pending result overwritten");

  a_one_in_flight : assert property (@(posedge clk) disable iff (!rst_n)
    req.valid |=> (state_r == dqr_pkg::S_WAIT))
    else $error("request taken without waiting for its result");

  a_wait_resolves : assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == dqr_pkg::S_WAIT) && !out_valid_r) |=> out_valid_r)
    else $error("result not delivered to a free output register");
`endif

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for deque_with_reverse
// Drives insert, remove and reverse requests with random gaps and result
// stalls, predicts each result from a ring buffer with a direction flag,
// and compares every result field by field in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH       = dqr_pkg::DEPTH_DEF;
  localparam int unsigned RANDOM_REQS = 1523;
  localparam int unsigned CALM_TAIL   = 200;
  localparam int unsigned SETTLE      = 10;

  // Predicts one result per request and holds results still to arrive
  class deque_scoreboard;
    logic signed [31:0]  slot_q [DEPTH];
    int unsigned         front_slot;
    int unsigned         end_slot;
    int unsigned         held;
    bit                  flipped;
    dqr_pkg::out_item_t  awaited [$];
    int unsigned         errors;

    function int unsigned ring_next(int unsigned i);
      return (i + 1 == DEPTH) ? 0 : i + 1;
    endfunction

    function int unsigned ring_prev(int unsigned i);
      return (i == 0) ? DEPTH - 1 : i - 1;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    // Apply an accepted request to the ring and queue its result
    function void note_request(dqr_pkg::in_item_t req);
      dqr_pkg::out_item_t res;
      bit                 at_front;
      res = '0;
      res.status = dqr_pkg::ST_DONE;
      case (req.kind)
        dqr_pkg::KIND_INS_HEAD, dqr_pkg::KIND_INS_TAIL: begin
          // the logical head sits at the physical back while flipped
          at_front = (req.kind == dqr_pkg::KIND_INS_HEAD) ^ flipped;
          if (held >= DEPTH) begin
            res.status = dqr_pkg::ST_FULL;
          end else if (at_front) begin
            front_slot = ring_prev(front_slot);
            slot_q[front_slot] = req.value;
            held++;
          end else begin
            slot_q[end_slot] = req.value;
            end_slot = ring_next(end_slot);
            held++;
          end
        end
        dqr_pkg::KIND_REM_HEAD: begin
          if (held == 0) begin
            res.status = dqr_pkg::ST_EMPTY;
          end else if (flipped) begin
            end_slot = ring_prev(end_slot);
            res.removed_value = slot_q[end_slot];
            held--;
          end else begin
            res.removed_value = slot_q[front_slot];
            front_slot = ring_next(front_slot);
            held--;
          end
        end
        default: begin
          if (held >= 2) flipped = ~flipped;
        end
      endcase
      res.count = 5'(held);
      awaited.push_back(res);
    endfunction

    // Compare a result with the oldest prediction
    function void check_result(dqr_pkg::out_item_t got);
      dqr_pkg::out_item_t want;
      if (awaited.size() == 0) begin
        $error("result with no request outstanding: status %0d, value %0d, count %0d",
               got.status, got.removed_value, got.count);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.removed_value !== want.removed_value) begin
        $error("removed_value: expected %0d, got %0d", want.removed_value,
               got.removed_value);
        errors++;
      end
      if (got.count !== want.count) begin
        $error("count: expected %0d, got %0d", want.count, got.count);
        errors++;
      end
    endfunction
  endclass

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  dqr_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  dqr_pkg::out_item_t out_data;

  bit              quiet = 1'b0;
  deque_scoreboard sb    = new();

  deque_with_reverse #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Note requests before checking results so a same-edge pair stays ordered
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  // Stall the result side in random bursts, with calm stretches between
  initial begin : result_stall
    int unsigned hold;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        hold = $urandom_range(1, 13);
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // Present one request, after an optional gap, and hold it until taken
  task automatic send_req(dqr_pkg::kind_t k, logic signed [31:0] v);
    dqr_pkg::in_item_t req;
    req.kind  = k;
    req.value = v;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted result has arrived
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned        issued;
    int unsigned        phase_len;
    int unsigned        fill_cut;
    int unsigned        roll;
    bit                 calm_phase;
    bit                 drained;
    dqr_pkg::kind_t     k;
    logic signed [31:0] v;

    issued  = 0;
    drained = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty cases, extremes, reverse at one and two entries
    send_req(dqr_pkg::KIND_REM_HEAD, 32'sd0);
    send_req(dqr_pkg::KIND_REVERSE, 32'sd0);
    send_req(dqr_pkg::KIND_INS_HEAD, 32'sh7fffffff);
    send_req(dqr_pkg::KIND_REVERSE, 32'sd0);
    send_req(dqr_pkg::KIND_INS_TAIL, 32'sh80000000);
    send_req(dqr_pkg::KIND_REVERSE, 32'sd0);
    send_req(dqr_pkg::KIND_INS_HEAD, -32'sd1);
    send_req(dqr_pkg::KIND_INS_TAIL, 32'sd0);
    send_req(dqr_pkg::KIND_REM_HEAD, 32'sh5a5a5a5a);
    send_req(dqr_pkg::KIND_REVERSE, 32'sd0);
    // fill to the brim from both ends, then push against a full ring
    for (int i = 0; i < 13; i++) begin
      send_req((i % 2 == 0) ? dqr_pkg::KIND_INS_HEAD : dqr_pkg::KIND_INS_TAIL, $urandom);
    end
    send_req(dqr_pkg::KIND_INS_HEAD, 32'sh12345678);
    send_req(dqr_pkg::KIND_INS_TAIL, 32'sh76543210);
    send_req(dqr_pkg::KIND_REVERSE, 32'sd0);
    send_req(dqr_pkg::KIND_REM_HEAD, 32'sd0);

    // Random phases: filling, draining or balanced, so full and empty recur
    while (issued < RANDOM_REQS) begin
      phase_len  = $urandom_range(10, 60);
      calm_phase = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 2))
        0:       fill_cut = 80;
        1:       fill_cut = 40;
        default: fill_cut = 56;
      endcase
      for (int i = 0; i < phase_len && issued < RANDOM_REQS; i++) begin
        quiet = calm_phase || (issued >= RANDOM_REQS - CALM_TAIL);
        if (!drained && issued >= RANDOM_REQS / 2) begin
          drain_results();
          drained = 1'b1;
        end
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
          k = dqr_pkg::KIND_REVERSE;
        end else if (roll < fill_cut) begin
          k = ($urandom_range(0, 1) != 0) ? dqr_pkg::KIND_INS_HEAD : dqr_pkg::KIND_INS_TAIL;
        end else begin
          k = dqr_pkg::KIND_REM_HEAD;
        end
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 3))
            0:       v = 32'sh80000000;
            1:       v = 32'sh7fffffff;
            2:       v = 32'sd0;
            default: v = -32'sd1;
          endcase
        end else begin
          v = $urandom;
        end
        send_req(k, v);
        issued++;
      end
    end

    // Wait out the remaining results, then let the block settle
    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0) begin
      $display("deque_with_reverse: match");
    end else begin
      $display("deque_with_reverse: mismatch");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin : watchdog
    #2ms;
    $display("deque_with_reverse: mismatch");
    $finish;
  end

endmodule
